FILE: src/hrc_pkg.sv
// Shared types for the history ring with browse cursor.
package hrc_pkg;

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_UP    = 2'd1,
		MODE_DOWN  = 2'd2,
		MODE_QUERY = 2'd3
	} mode_t;

	typedef struct packed {
		logic hit;
		logic at_top;
		logic at_bottom;
	} step_t;

endpackage

FILE: src/hrc_ring.sv
// Single-port history store with registered read data.
module hrc_ring import hrc_pkg::*; #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32,
	parameter int IDX_W      = 6
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic                  rd_en,
	input  logic [IDX_W-1:0]      addr,
	input  logic [DATA_WIDTH-1:0] wr_data,
	output logic [DATA_WIDTH-1:0] rd_data
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: src/hrc_ctrl.sv
// Start, end and cursor indexes of the ring, and per-item step decode.
module hrc_ctrl import hrc_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  mode_t            mode,
	output logic             wr_en,
	output logic             rd_en,
	output logic [IDX_W-1:0] addr,
	output step_t            step
);

	localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

	logic [IDX_W-1:0] start_q, end_q, cursor_q;
	logic             full_q;
	logic [IDX_W-1:0] start_d, end_d, cursor_d;
	logic             full_d;
	logic             moved;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v);
		return (v == LAST) ? '0 : v + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] v);
		return (v == '0) ? LAST : v - 1'b1;
	endfunction

	always_comb begin
		start_d  = start_q;
		end_d    = end_q;
		cursor_d = cursor_q;
		full_d   = full_q;
		moved    = 1'b0;
		addr     = end_q;
		unique case (mode)
			MODE_ADD: begin
				end_d = wrap_inc(end_q);
				if (full_q || end_d == '0) begin
					start_d = wrap_inc(start_q);
					full_d  = 1'b1;
				end
				cursor_d = end_d;
			end
			MODE_UP: begin
				if (cursor_q != end_q) begin
					cursor_d = wrap_inc(cursor_q);
					moved    = 1'b1;
				end
				addr = cursor_d;
			end
			MODE_DOWN: begin
				if (cursor_q != start_q) begin
					cursor_d = wrap_dec(cursor_q);
					moved    = 1'b1;
				end
				addr = cursor_d;
			end
			MODE_QUERY: begin
			end
			default: begin
			end
		endcase
	end

	// slots fill in order from zero, so a slot is written once full or below end
	assign step.hit       = moved && (full_q || cursor_d < end_q);
	assign step.at_top    = cursor_d == end_d;
	assign step.at_bottom = cursor_d == start_d;

	assign wr_en = step_en && mode == MODE_ADD;
	assign rd_en = step_en && moved;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			end_q    <= '0;
			cursor_q <= '0;
			full_q   <= 1'b0;
		end else if (step_en) begin
			start_q  <= start_d;
			end_q    <= end_d;
			cursor_q <= cursor_d;
			full_q   <= full_d;
		end
	end

endmodule

FILE: src/history_ring_with_cursor_top.sv
// Top level of the history ring with browse cursor: item registers and handshake.
//
//  channel | signals                          | direction
//  in      | in_valid in_ready mode entry_data | into the block
//  out     | out_valid out_ready entry_valid   | out of the block
//          | entry_out at_top at_bottom        |
//
// One item per cycle unless the output stalls; path: input register, result register.
// The index update and the single store port act on one item per cycle.
// Reset clears the indexes, the full flag and both stage valids; the store
// is not cleared, unwritten slots are never returned.
// A stalled result holds its register and the input register behind it.
module history_ring_with_cursor_top import hrc_pkg::*; #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] entry_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        entry_valid,
	output logic [31:0] entry_out,
	output logic        at_top,
	output logic        at_bottom
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                  vld_s1, vld_s2;
	mode_t                 mode_s1;
	logic [DATA_WIDTH-1:0] data_s1;
	step_t                 step_s2;
	logic                  adv_s1;
	logic                  wr_en, rd_en;
	logic [IDX_W-1:0]      addr;
	step_t                 step;
	logic [DATA_WIDTH-1:0] rd_data;

	assign adv_s1   = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (adv_s1) begin
				vld_s2 <= 1'b1;
			end else if (out_ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode_t'(mode);
			data_s1 <= DATA_WIDTH'(entry_data);
		end
		if (adv_s1) begin
			step_s2 <= step;
		end
	end

	hrc_ctrl #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv_s1),
		.mode    (mode_s1),
		.wr_en   (wr_en),
		.rd_en   (rd_en),
		.addr    (addr),
		.step    (step)
	);

	hrc_ring #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.IDX_W      (IDX_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.rd_en   (rd_en),
		.addr    (addr),
		.wr_data (data_s1),
		.rd_data (rd_data)
	);

	assign out_valid   = vld_s2;
	assign entry_valid = step_s2.hit;
	assign entry_out   = step_s2.hit ? 32'(rd_data) : 32'd0;
	assign at_top      = step_s2.at_top;
	assign at_bottom   = step_s2.at_bottom;

	a_hit_only_on_move: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && step.hit |-> mode_s1 == MODE_UP || mode_s1 == MODE_DOWN)
		else $error("slot returned by a mode that does not move the cursor");

	a_add_leaves_top: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && mode_s1 == MODE_ADD |=> step_s2.at_top && !step_s2.hit)
		else $error("add did not leave the cursor at the top");

	a_block_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !in_ready |-> vld_s2 && !out_ready)
		else $error("input held back without an output stall");

endmodule
